// ===== hw/rtl/selective_repeat_arq_sender_core_defines.svh =====
// Assertion helpers for the RTL of the ARQ sender.
`ifndef SELECTIVE_REPEAT_ARQ_SENDER_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_ARQ_SENDER_CORE_DEFINES_SVH

`ifndef SYNTH
// Concurrent assertion on an explicit clock and active-low reset
`define SRARQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent assertion on the block clock and reset
`define SRARQ_ASSERT(label, prop, msg) \
  `SRARQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define SRARQ_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define SRARQ_ASSERT(label, prop, msg)
`endif

`endif

// ===== hw/rtl/srarq_pkg.sv =====
package srarq_pkg;

  // Default sizing
  localparam int unsigned WindowMaxDefault = 8;
  localparam int unsigned SeqBitsDefault   = 16;
  localparam int unsigned TimerBitsDefault = 16;

  // Register file
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned WinRegW  = 4;
  localparam int unsigned TmoRegW  = 16;

  localparam logic [WinRegW-1:0] WindowSizeReset = 4'd4;
  localparam logic [TmoRegW-1:0] TimeoutReset    = 16'd1000;

  typedef enum logic {
    RegWindow  = 1'b0,
    RegTimeout = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActAck   = 2'd1,
    ActNak   = 2'd2,
    ActTick  = 2'd3
  } action_e;

  typedef enum logic [7:0] {
    StIdle    = 8'b0000_0001,
    StRetire  = 8'b0000_0010,
    StRefill  = 8'b0000_0100,
    StNakRd   = 8'b0000_1000,
    StNakWr   = 8'b0001_0000,
    StTickRd  = 8'b0010_0000,
    StTickWr  = 8'b0100_0000,
    StTickEnd = 8'b1000_0000
  } state_e;

endpackage

// ===== hw/rtl/srarq_slot_ram.sv =====
// Per-slot storage: one write port, one registered read port
module srarq_slot_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/selective_repeat_arq_sender_core.sv =====
// Selective-repeat ARQ sender window.
// Input channel (in_valid_i/in_ready_o): one event per transfer: start/refill,
// cumulative ACK, NAK or timer tick, with the feedback frame number and a
// corrupted flag. Output channel (out_valid_o/out_ready_i): one frame number to
// transmit per transfer, with a retransmit flag; last_o marks the final frame
// caused by an event. Events that cause nothing produce no transfer.
// Items are handled one at a time; in_ready_o is high while the sequencer idles.
// Start/refill sends one frame per cycle while the receiver takes them; an ACK
// retires the acknowledged frames, then refills; a NAK reads its slot, then
// resends; a tick reads and writes back each window slot in turn.
// A result sits in the output register while the next event is taken.
// When the receiver stalls, the sequencer holds at the next frame to send.
// Reset: window 4, timeout 1000, empty window, no frames outstanding; the
// slot memory needs no clearing pass. Writing the window size empties the
// window the same way. APB registers: 0x0 window_size, 0x4 timeout_ticks.
`include "selective_repeat_arq_sender_core_defines.svh"

module selective_repeat_arq_sender_core #(
  parameter int unsigned WindowMax = srarq_pkg::WindowMaxDefault,
  parameter int unsigned SeqBits   = srarq_pkg::SeqBitsDefault,
  parameter int unsigned TimerBits = srarq_pkg::TimerBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [SeqBits-1:0]            seq_num_i,
  input  logic                          corrupted_i,
  // frame output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SeqBits-1:0]            frame_seq_o,
  output logic                          retransmit_o,
  output logic                          last_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srarq_pkg::CfgAddrW-1:0] paddr,
  input  logic [srarq_pkg::CfgDataW-1:0] pwdata,
  output logic [srarq_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned SlotsMax = 2 * WindowMax;
  localparam int unsigned SlotW    = (SlotsMax > 1) ? $clog2(SlotsMax) : 1;
  localparam int unsigned WinW     = $clog2(WindowMax + 1);
  localparam int unsigned CntW     = $clog2(SlotsMax + 1);
  localparam int unsigned SumW     = CntW + 1;
  localparam int unsigned RamW     = SeqBits + TimerBits;

  // Registers
  logic [srarq_pkg::WinRegW-1:0] window_size_q;
  logic [srarq_pkg::TmoRegW-1:0] timeout_q;

  srarq_pkg::state_e  state_q, state_d;
  logic [SeqBits-1:0] lower_edge_q, lower_edge_d;
  logic [SeqBits-1:0] upper_edge_q, upper_edge_d;
  logic [SlotW-1:0]   lower_slot_q, lower_slot_d;
  logic [SlotsMax-1:0] outst_q, outst_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               pend_vld_q, pend_vld_d;
  logic [SeqBits-1:0] pend_seq_q, pend_seq_d;
  logic               out_valid_q, out_valid_d;
  logic [SeqBits-1:0] out_seq_q, out_seq_d;
  logic               out_retx_q, out_retx_d;
  logic               out_last_q, out_last_d;

  // Slot memory port
  logic               ram_we, ram_re;
  logic [SlotW-1:0]   ram_waddr, ram_raddr;
  logic [RamW-1:0]    ram_wdata, ram_rdata;
  logic [SeqBits-1:0] rd_frame;
  logic [TimerBits-1:0] rd_timer, timer_dec;

  // Derived values
  logic [WinW-1:0]      win;
  logic [CntW-1:0]      slots;
  logic [SeqBits-1:0]   win_seq, used, fb_off;
  logic [TimerBits-1:0] reload;
  logic                 fb_ok, out_free, load_out, cfg_we;
  logic [SlotW-1:0]     tick_slot, fill_slot, next_lower;
  srarq_pkg::action_e   act;

  // Slot index arithmetic modulo the active slot count
  function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] base,
                                                input logic [CntW-1:0]  ofs,
                                                input logic [CntW-1:0]  num);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(ofs);
    if (sum >= SumW'(num)) begin
      sum = sum - SumW'(num);
    end
    return SlotW'(sum);
  endfunction

  // Effective window, clamped to [1, WindowMax]
  always_comb begin
    if (window_size_q == '0) begin
      win = WinW'(1);
    end else if (int'(window_size_q) > WindowMax) begin
      win = WinW'(WindowMax);
    end else begin
      win = WinW'(window_size_q);
    end
  end

  assign slots      = CntW'({win, 1'b0});
  assign win_seq    = SeqBits'(win);
  assign used       = upper_edge_q - lower_edge_q;
  assign fb_off     = seq_num_i - lower_edge_q;
  assign fb_ok      = !corrupted_i && (fb_off < used);
  assign reload     = (TimerBits'(timeout_q) == '0) ? TimerBits'(1) : TimerBits'(timeout_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign tick_slot  = slot_add(lower_slot_q, cnt_q, slots);
  assign fill_slot  = slot_add(lower_slot_q, CntW'(used), slots);
  assign next_lower = slot_add(lower_slot_q, CntW'(1), slots);
  assign act        = srarq_pkg::action_e'(action_i);

  assign rd_timer  = ram_rdata[TimerBits-1:0];
  assign rd_frame  = ram_rdata[TimerBits +: SeqBits];
  assign timer_dec = rd_timer - TimerBits'(1);

  assign cfg_we = psel && penable && pwrite;

  // Sequencer: works through the window one slot per step
  always_comb begin
    state_d      = state_q;
    lower_edge_d = lower_edge_q;
    upper_edge_d = upper_edge_q;
    lower_slot_d = lower_slot_q;
    outst_d      = outst_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    pend_vld_d   = pend_vld_q;
    pend_seq_d   = pend_seq_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_seq_d    = out_seq_q;
    out_retx_d   = out_retx_q;
    out_last_d   = out_last_q;
    load_out     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_wdata    = {rd_frame, reload};
    ram_re       = 1'b0;
    ram_raddr    = slot_q;

    case (state_q)
      srarq_pkg::StIdle: begin
        if (in_valid_i) begin
          case (act)
            srarq_pkg::ActStart: state_d = srarq_pkg::StRefill;
            srarq_pkg::ActAck: begin
              cnt_d   = CntW'(fb_off);
              state_d = fb_ok ? srarq_pkg::StRetire : srarq_pkg::StIdle;
            end
            srarq_pkg::ActNak: begin
              slot_d  = slot_add(lower_slot_q, CntW'(fb_off), slots);
              state_d = fb_ok ? srarq_pkg::StNakRd : srarq_pkg::StIdle;
            end
            default: begin
              cnt_d   = '0;
              state_d = (used == '0) ? srarq_pkg::StIdle : srarq_pkg::StTickRd;
            end
          endcase
        end
      end

      // Retire acknowledged frames from the lower edge, one per cycle
      srarq_pkg::StRetire: begin
        outst_d[lower_slot_q] = 1'b0;
        lower_slot_d = next_lower;
        lower_edge_d = lower_edge_q + SeqBits'(1);
        if (cnt_q == '0) begin
          state_d = srarq_pkg::StRefill;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end

      // Send new frames until the window is full
      srarq_pkg::StRefill: begin
        if (used >= win_seq) begin
          state_d = srarq_pkg::StIdle;
        end else if (out_free) begin
          ram_we             = 1'b1;
          ram_waddr          = fill_slot;
          ram_wdata          = {upper_edge_q, reload};
          outst_d[fill_slot] = 1'b1;
          load_out           = 1'b1;
          out_seq_d          = upper_edge_q;
          out_retx_d         = 1'b0;
          out_last_d         = (used + SeqBits'(1)) == win_seq;
          upper_edge_d       = upper_edge_q + SeqBits'(1);
          if (out_last_d) begin
            state_d = srarq_pkg::StIdle;
          end
        end
      end

      srarq_pkg::StNakRd: begin
        ram_re  = 1'b1;
        state_d = srarq_pkg::StNakWr;
      end

      // Resend one frame and restart its timer
      srarq_pkg::StNakWr: begin
        if (!outst_q[slot_q]) begin
          state_d = srarq_pkg::StIdle;
        end else if (out_free) begin
          ram_we     = 1'b1;
          load_out   = 1'b1;
          out_seq_d  = rd_frame;
          out_retx_d = 1'b1;
          out_last_d = 1'b1;
          state_d    = srarq_pkg::StIdle;
        end
      end

      srarq_pkg::StTickRd: begin
        ram_re    = 1'b1;
        ram_raddr = tick_slot;
        slot_d    = tick_slot;
        state_d   = srarq_pkg::StTickWr;
      end

      // Count down one timer; an expired frame is held back one step so
      // that the final resend of the tick can carry the last flag
      srarq_pkg::StTickWr: begin
        if (outst_q[slot_q] && (rd_timer != '0) && (timer_dec == '0)) begin
          if (!pend_vld_q || out_free) begin
            ram_we     = 1'b1;
            pend_vld_d = 1'b1;
            pend_seq_d = rd_frame;
            if (pend_vld_q) begin
              load_out   = 1'b1;
              out_seq_d  = pend_seq_q;
              out_retx_d = 1'b1;
              out_last_d = 1'b0;
            end
            cnt_d   = cnt_q + CntW'(1);
            state_d = ((SeqBits'(cnt_q) + SeqBits'(1)) == used) ?
                      srarq_pkg::StTickEnd : srarq_pkg::StTickRd;
          end
        end else begin
          if (outst_q[slot_q] && (rd_timer != '0)) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_frame, timer_dec};
          end
          cnt_d   = cnt_q + CntW'(1);
          state_d = ((SeqBits'(cnt_q) + SeqBits'(1)) == used) ?
                    srarq_pkg::StTickEnd : srarq_pkg::StTickRd;
        end
      end

      srarq_pkg::StTickEnd: begin
        if (!pend_vld_q) begin
          state_d = srarq_pkg::StIdle;
        end else if (out_free) begin
          load_out   = 1'b1;
          out_seq_d  = pend_seq_q;
          out_retx_d = 1'b1;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = srarq_pkg::StIdle;
        end
      end

      default: state_d = srarq_pkg::StIdle;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end

    // A new window size empties the window
    if (cfg_we && (srarq_pkg::reg_idx_e'(paddr[2]) == srarq_pkg::RegWindow)) begin
      lower_edge_d = '0;
      upper_edge_d = '0;
      lower_slot_d = '0;
      outst_d      = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srarq_pkg::StIdle;
      lower_edge_q <= '0;
      upper_edge_q <= '0;
      lower_slot_q <= '0;
      outst_q      <= '0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lower_edge_q <= lower_edge_d;
      upper_edge_q <= upper_edge_d;
      lower_slot_q <= lower_slot_d;
      outst_q      <= outst_d;
      pend_vld_q   <= pend_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    slot_q     <= slot_d;
    pend_seq_q <= pend_seq_d;
    out_seq_q  <= out_seq_d;
    out_retx_q <= out_retx_d;
    out_last_q <= out_last_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= srarq_pkg::WindowSizeReset;
      timeout_q     <= srarq_pkg::TimeoutReset;
    end else if (cfg_we) begin
      if (srarq_pkg::reg_idx_e'(paddr[2]) == srarq_pkg::RegWindow) begin
        window_size_q <= pwdata[srarq_pkg::WinRegW-1:0];
      end else begin
        timeout_q <= pwdata[srarq_pkg::TmoRegW-1:0];
      end
    end
  end

  assign prdata = (srarq_pkg::reg_idx_e'(paddr[2]) == srarq_pkg::RegWindow) ?
                  srarq_pkg::CfgDataW'(window_size_q) : srarq_pkg::CfgDataW'(timeout_q);
  assign pready = 1'b1;

  // Frame number and timer of each slot; each entry is read at most once
  // per event and written back before the next entry is read
  srarq_slot_ram #(
    .Depth (SlotsMax),
    .Width (RamW),
    .AddrW (SlotW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign in_ready_o   = (state_q == srarq_pkg::StIdle);
  assign out_valid_o  = out_valid_q;
  assign frame_seq_o  = out_seq_q;
  assign retransmit_o = out_retx_q;
  assign last_o       = out_last_q;

  // Checks
  `SRARQ_ASSERT(a_outst_matches_window,
    (state_q == srarq_pkg::StIdle) |-> ($countones(outst_q) == int'(used)),
    "outstanding flags disagree with the window edges")
  `SRARQ_ASSERT(a_window_bound, used <= win_seq, "window holds more frames than allowed")
  `SRARQ_ASSERT(a_lower_slot_range, CntW'(lower_slot_q) < slots, "lower slot out of range")
  `SRARQ_ASSERT(a_no_overwrite, load_out |-> (!out_valid_q || out_ready_i),
    "output register loaded while a result is pending")

endmodule

// ===== tb/selective_repeat_arq_sender_core_tb.sv =====
module selective_repeat_arq_sender_core_tb;
  import srarq_pkg::*;

  localparam int unsigned WinMax       = WindowMaxDefault;
  localparam int unsigned Slots        = 2 * WinMax;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;

  typedef struct packed {
    logic [15:0] seq;
    logic        retx;
    logic        last;
  } frame_t;

  typedef enum logic {
    RowItem,
    RowCfg
  } row_kind_e;

  // One directed step: an event (n >= 0 types the frames in, n < 0 defers to the
  // window model) or a register write.
  typedef struct {
    row_kind_e   kind;
    action_e     act;
    logic [15:0] seq;
    logic        bad;
    int          n;
    logic [15:0] first;
    logic        retx;
    reg_idx_e    sel;
    logic [31:0] val;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i = ActStart;
  logic [15:0]         seq_num_i = '0;
  logic                corrupted_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [15:0]         frame_seq_o;
  logic                retransmit_o;
  logic                last_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  selective_repeat_arq_sender_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .seq_num_i    (seq_num_i),
    .corrupted_i  (corrupted_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_seq_o  (frame_seq_o),
    .retransmit_o (retransmit_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Window model state and register copies
  logic [3:0]  win_reg;
  logic [15:0] tmo_reg;
  logic [15:0] win_lo;
  logic [15:0] win_hi;
  int unsigned lo_slot;
  bit          pending [Slots];
  logic [15:0] slot_seq [Slots];
  logic [15:0] ticks_left [Slots];

  frame_t frames_new[$];
  frame_t frames_due[$];
  frame_t due;
  int     mismatches = 0;
  int     tx_idle_pct = 8;
  int     rx_idle_pct = 58;
  int     hold_req = 0;
  int     hold_ack;
  int     hold_left;

  step_t plan [31] = '{
    '{RowItem, ActTick,  16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActAck,   16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActStart, 16'h0000, 1'b0,  4, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActNak,   16'h0002, 1'b1,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActNak,   16'h0002, 1'b0,  1, 16'd2,  1'b1, RegWindow,  32'd0},
    '{RowItem, ActNak,   16'hFFFF, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActAck,   16'h0001, 1'b1,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActAck,   16'h0001, 1'b0,  2, 16'd4,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActStart, 16'hFFFF, 1'b1,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegTimeout, 32'd0},
    '{RowItem, ActAck,   16'h0005, 1'b0,  4, 16'd6,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActTick,  16'h0000, 1'b0,  4, 16'd6,  1'b1, RegWindow,  32'd0},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActStart, 16'h0000, 1'b0,  1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActTick,  16'h0000, 1'b0,  1, 16'd0,  1'b1, RegWindow,  32'd0},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd15},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegTimeout, 32'd65535},
    '{RowItem, ActStart, 16'h0000, 1'b0,  8, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActAck,   16'h0007, 1'b0,  8, 16'd8,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActNak,   16'h000F, 1'b0,  1, 16'd15, 1'b1, RegWindow,  32'd0},
    '{RowItem, ActTick,  16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegTimeout, 32'd2},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd8},
    '{RowItem, ActStart, 16'h0000, 1'b0, -1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActTick,  16'h0000, 1'b1, -1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActTick,  16'h0000, 1'b0, -1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActNak,   16'h0003, 1'b0, -1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowCfg,  ActStart, 16'h0000, 1'b0,  0, 16'd0,  1'b0, RegWindow,  32'd1},
    '{RowItem, ActStart, 16'h0000, 1'b0, -1, 16'd0,  1'b0, RegWindow,  32'd0},
    '{RowItem, ActAck,   16'h0000, 1'b0, -1, 16'd0,  1'b0, RegWindow,  32'd0}
  };

  function automatic int unsigned win_eff();
    int unsigned w;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > WinMax) w = WinMax;
    return w;
  endfunction

  // zero timeout reloads with one tick
  function automatic logic [15:0] reload_ticks();
    return (tmo_reg == 16'd0) ? 16'd1 : tmo_reg;
  endfunction

  function automatic void empty_window();
    win_lo  = '0;
    win_hi  = '0;
    lo_slot = 0;
    for (int i = 0; i < Slots; i++) begin
      pending[i]    = 1'b0;
      slot_seq[i]   = '0;
      ticks_left[i] = '0;
    end
  endfunction

  // Send new frames until the window holds W of them
  function automatic void open_frames();
    int unsigned w;
    int unsigned s;
    logic [15:0] used;
    w    = win_eff();
    used = win_hi - win_lo;
    while (used < w) begin
      s             = (lo_slot + used) % (2 * w);
      pending[s]    = 1'b1;
      slot_seq[s]   = win_hi;
      ticks_left[s] = reload_ticks();
      frames_new.push_back('{seq: win_hi, retx: 1'b0, last: 1'b0});
      win_hi++;
      used++;
    end
  endfunction

  // Apply one event to the window and collect the frames it sends
  function automatic void advance_window(action_e act, logic [15:0] seq, logic bad);
    int unsigned slots;
    int unsigned s;
    logic [15:0] used;
    logic [15:0] off;
    frames_new.delete();
    slots = 2 * win_eff();
    used  = win_hi - win_lo;
    off   = seq - win_lo;
    if (lo_slot >= slots) lo_slot = lo_slot % slots;
    case (act)
      ActStart: open_frames();
      ActAck: begin
        if (!bad && off < used) begin
          for (int k = 0; k <= off; k++) begin
            pending[lo_slot]    = 1'b0;
            ticks_left[lo_slot] = '0;
            lo_slot             = (lo_slot + 1) % slots;
            win_lo++;
          end
          open_frames();
        end
      end
      ActNak: begin
        s = (lo_slot + off) % slots;
        if (!bad && off < used && pending[s]) begin
          ticks_left[s] = reload_ticks();
          frames_new.push_back('{seq: slot_seq[s], retx: 1'b1, last: 1'b0});
        end
      end
      default: begin
        // expired frames go out in window order
        for (int k = 0; k < used && k < slots; k++) begin
          s = (lo_slot + k) % slots;
          if (pending[s] && ticks_left[s] != 0) begin
            ticks_left[s]--;
            if (ticks_left[s] == 0) begin
              ticks_left[s] = reload_ticks();
              frames_new.push_back('{seq: slot_seq[s], retx: 1'b1, last: 1'b0});
            end
          end
        end
      end
    endcase
    if (frames_new.size() > 0) frames_new[$].last = 1'b1;
  endfunction

  // Drop valid, wait for every due frame, then let the sequencer finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Offer one event, wait for its transfer and queue the frames it causes
  task automatic send_event(action_e act, logic [15:0] seq, logic bad, int typed_n,
                            logic [15:0] first, logic retx);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    seq_num_i   <= seq;
    corrupted_i <= bad;
    do @(posedge clk_i); while (!in_ready_o);
    advance_window(act, seq, bad);
    if (typed_n < 0) begin
      foreach (frames_new[j]) frames_due.push_back(frames_new[j]);
    end else begin
      for (int i = 0; i < typed_n; i++) begin
        frames_due.push_back('{seq: first + 16'(i), retx: retx, last: (i == typed_n - 1)});
      end
    end
  endtask

  // Mostly feedback inside the window; a few events are pure noise
  task automatic send_random();
    logic [15:0] span;
    logic [15:0] seq;
    int          roll;
    action_e     act;
    logic        bad;
    span = win_hi - win_lo;
    roll = $urandom_range(99);
    seq  = 16'($urandom);
    bad  = ($urandom_range(9) == 0);
    if (roll < 20) act = ActStart;
    else if (roll < 50) act = ActAck;
    else if (roll < 70) act = ActNak;
    else if (roll < 94) act = ActTick;
    else act = action_e'($urandom_range(3));
    if (roll < 94 && span != 0 && $urandom_range(9) < 8) begin
      seq = win_lo + 16'($urandom_range(span - 1));
    end
    send_event(act, seq, bad, -1, 16'd0, 1'b0);
  endtask

  // Register write with read-back, only once the block is idle
  task automatic write_reg(reg_idx_e sel, logic [31:0] val);
    logic [31:0] want;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(int'(sel) * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == RegWindow) begin
      win_reg = val[3:0];
      empty_window();
      want = {28'd0, val[3:0]};
    end else begin
      tmo_reg = val[15:0];
      want = {16'd0, val[15:0]};
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      $display("%0t: register %0d read expected %h got %h", $time, sel, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_ack    <= 0;
      hold_left   <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each frame transfer with the oldest due frame
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        $display("%0t: frame expected none got seq %h retx %b last %b", $time,
                 frame_seq_o, retransmit_o, last_o);
      end else begin
        due = frames_due.pop_front();
        if (frame_seq_o !== due.seq) begin
          mismatches++;
          $display("%0t: frame_seq expected %h got %h", $time, due.seq, frame_seq_o);
        end
        if (retransmit_o !== due.retx) begin
          mismatches++;
          $display("%0t: retransmit expected %b got %b", $time, due.retx, retransmit_o);
        end
        if (last_o !== due.last) begin
          mismatches++;
          $display("%0t: last expected %b got %b", $time, due.last, last_o);
        end
      end
    end
  end

  initial begin
    win_reg = WindowSizeReset;
    tmo_reg = TimeoutReset;
    empty_window();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed steps
    foreach (plan[r]) begin
      if (plan[r].kind == RowCfg) begin
        write_reg(plan[r].sel, plan[r].val);
      end else begin
        send_event(plan[r].act, plan[r].seq, plan[r].bad, plan[r].n, plan[r].first,
                   plan[r].retx);
      end
    end

    // random phases: sender idles lightly, then receiver idles lightly, then neither
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_reg(RegWindow, (p == 1) ? $urandom_range(8, 1) : $urandom_range(15));
      write_reg(RegTimeout, (p == 2) ? $urandom_range(3) : $urandom_range(8, 1));
      for (int n = 0; n < 67; n++) begin
        if (p == 0 && n == 10) hold_req <= hold_req + 1;
        if (p == 1 && n == 33) settle();
        send_random();
      end
    end

    settle();
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("selective_repeat_arq_sender_core verification clean");
    end else begin
      $display("selective_repeat_arq_sender_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("selective_repeat_arq_sender_core verification failed");
    $finish;
  end

endmodule
